FILE: rtl/imdu_pkg.sv
// Package for the integer multiply/divide unit.
// Holds operation codes and fixed field widths; no dependencies.
package imdu_pkg;
    localparam int OP_W  = 3;
    localparam int TAG_W = 5;
    localparam int IN_W  = 32;

    typedef enum logic [OP_W-1:0] {
        OP_MUL    = 3'd0,
        OP_MULH   = 3'd1,
        OP_MULHSU = 3'd2,
        OP_MULHU  = 3'd3,
        OP_DIV    = 3'd4,
        OP_DIVU   = 3'd5,
        OP_REM    = 3'd6,
        OP_REMU   = 3'd7
    } t_op;
endpackage

FILE: rtl/imdu_if.sv
// Valid/ready channel interfaces for the multiply/divide unit.
// Depends on imdu_pkg.
interface imdu_req_if
    import imdu_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [IN_W-1:0]    operand_a;
    logic [IN_W-1:0]    operand_b;
    logic [TAG_W-1:0]   dest_tag;
    modport source (output valid, op, operand_a, operand_b, dest_tag, input ready);
    modport sink   (input valid, op, operand_a, operand_b, dest_tag, output ready);
endinterface

interface imdu_rsp_if
    import imdu_pkg::*;
    #(parameter int DATA_WIDTH = 32)
    ;
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] result;
    logic [TAG_W-1:0]      result_tag;
    modport source (output valid, result, result_tag, input ready);
    modport sink   (input valid, result, result_tag, output ready);
endinterface

FILE: rtl/integer_multiply_divide_unit.sv
// Integer multiply/divide unit, RV32M operations.
// Every op takes the same path; throughput one item per cycle unless the output stalls.
// Division is a radix-2 restoring pipeline, one quotient bit per stage; the
// multiply runs as a registered (DATA_WIDTH+1)x(DATA_WIDTH+1) product alongside it.
// Stalls freeze the whole pipeline. Synchronous active-low reset clears valids.
// Depends on imdu_pkg and imdu_if.
module integer_multiply_divide_unit
    import imdu_pkg::*;
    #(parameter int DATA_WIDTH = 32)
    (
    input  logic        i_clk,
    input  logic        i_rst_n,
    imdu_req_if.sink    i_req,
    imdu_rsp_if.source  o_rsp
    );

    localparam int W  = DATA_WIDTH;
    localparam int NS = W;

    logic adv;
    assign adv = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = adv;

    // stage 0: decode
    logic [W-1:0] a_w, b_w;
    assign a_w = W'(i_req.operand_a);
    assign b_w = W'(i_req.operand_b);

    t_op          r_op;
    logic         r_v0;
    logic [TAG_W-1:0] r_tag0;
    logic [W:0]   r_ma, r_mb;
    logic [W-1:0] r_a0, r_b0;
    logic [W-1:0] r_da, r_db;
    logic         r_neg_q, r_neg_r, r_bz;
    logic         sa, sb, sgn_div;
    logic [W-1:0] abs_a, abs_b;

    always_comb begin
        sgn_div = (t_op'(i_req.op) == OP_DIV) || (t_op'(i_req.op) == OP_REM);
        sa = a_w[W-1] && sgn_div;
        sb = b_w[W-1] && sgn_div;
        abs_a = sa ? (~a_w + W'(1)) : a_w;
        abs_b = sb ? (~b_w + W'(1)) : b_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_req.valid;
        end
        if (adv) begin
            r_op   <= t_op'(i_req.op);
            r_tag0 <= i_req.dest_tag;
            r_a0   <= a_w;
            r_b0   <= b_w;
            r_ma   <= {(t_op'(i_req.op) == OP_MULH || t_op'(i_req.op) == OP_MULHSU)
                       && a_w[W-1], a_w};
            r_mb   <= {(t_op'(i_req.op) == OP_MULH) && b_w[W-1], b_w};
            r_da   <= abs_a;
            r_db   <= abs_b;
            r_neg_q <= sa ^ sb;
            r_neg_r <= sa;
            r_bz   <= (b_w == '0);
        end
    end

    // multiply, registered, then carried down a delay line
    logic [2*W+1:0] prod;
    logic [W-1:0]   mres;
    assign prod = $signed(r_ma) * $signed(r_mb);
    assign mres = (r_op == OP_MUL) ? prod[W-1:0] : prod[2*W-1:W];

    // divide stages
    logic [W-1:0] r_rem [NS+1];
    logic [W-1:0] r_quo [NS+1];
    logic [W-1:0] r_dvs [NS+1];
    logic [W-1:0] r_mr  [NS+1];
    logic [W-1:0] r_af  [NS+1];
    logic         r_v   [NS+1];
    logic         r_isd [NS+1];
    logic         r_isr [NS+1];
    logic         r_nq  [NS+1];
    logic         r_nr  [NS+1];
    logic         r_bzs [NS+1];
    logic [TAG_W-1:0] r_tg [NS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= r_v0;
        end
        if (adv) begin
            r_rem[0] <= '0;
            r_quo[0] <= r_da;
            r_dvs[0] <= r_db;
            r_mr[0]  <= mres;
            r_af[0]  <= r_a0;
            r_isd[0] <= r_op[2];
            r_isr[0] <= r_op[1];
            r_nq[0]  <= r_neg_q;
            r_nr[0]  <= r_neg_r;
            r_bzs[0] <= r_bz;
            r_tg[0]  <= r_tag0;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [W:0] trial;
        logic [W:0] sh;
        assign sh    = {r_rem[s], r_quo[s][W-1]};
        assign trial = sh - {1'b0, r_dvs[s]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (adv) begin
                r_v[s+1] <= r_v[s];
            end
            if (adv) begin
                r_rem[s+1] <= trial[W] ? sh[W-1:0] : trial[W-1:0];
                r_quo[s+1] <= {r_quo[s][W-2:0], !trial[W]};
                r_dvs[s+1] <= r_dvs[s];
                r_mr[s+1]  <= r_mr[s];
                r_af[s+1]  <= r_af[s];
                r_isd[s+1] <= r_isd[s];
                r_isr[s+1] <= r_isr[s];
                r_nq[s+1]  <= r_nq[s];
                r_nr[s+1]  <= r_nr[s];
                r_bzs[s+1] <= r_bzs[s];
                r_tg[s+1]  <= r_tg[s];
            end
        end
    end

    // output stage
    logic [W-1:0] q, rm, fres;
    always_comb begin
        q  = r_nq[NS] ? (~r_quo[NS] + W'(1)) : r_quo[NS];
        rm = r_nr[NS] ? (~r_rem[NS] + W'(1)) : r_rem[NS];
        if (!r_isd[NS]) begin
            fres = r_mr[NS];
        end else if (r_isr[NS]) begin
            fres = r_bzs[NS] ? r_af[NS] : rm;
        end else begin
            fres = r_bzs[NS] ? '1 : q;
        end
    end

    logic             r_ov;
    logic [W-1:0]     r_res;
    logic [TAG_W-1:0] r_otag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS];
        end
        if (adv) begin
            r_res  <= fres;
            r_otag <= r_tg[NS];
        end
    end

    assign o_rsp.valid      = r_ov;
    assign o_rsp.result     = r_res;
    assign o_rsp.result_tag = r_otag;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.result))
        else $error("result changed under stall");
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |-> !i_req.ready)
        else $error("input taken during stall");
    a_divz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_v[NS] && r_isd[NS] && !r_isr[NS] && r_bzs[NS] |=> o_rsp.result == '1)
        else $error("divide by zero quotient wrong");
endmodule
